/* rtl/grcr_pkg.sv */
// Package for the grid raycast column renderer: constants, types and the sine table.
// No dependencies.
`timescale 1ns / 1ps
package grcr_pkg;

   localparam int MapWidthDef    = 16;
   localparam int MapHeightDef   = 16;
   localparam int ScreenWidthDef = 320;
   localparam int ScreenHeightDef = 200;
   localparam int MaxStepsDef    = 1000;

   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam logic [CsrIdxW-1:0] CSR_PLAYER_X     = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_PLAYER_Y     = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_PLAYER_ANGLE = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_HALF_FOV     = 2'd3;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_CAST  = 1'b1;

   localparam logic [18:0] STEP_Q24    = 19'd335544;
   localparam logic [7:0]  SHADE_FLOOR = 8'd25;
   localparam logic [7:0]  SHADE_TOP   = 8'd255;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_SINE,
      ST_DELTA,
      ST_STEP,
      ST_CHECK,
      ST_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       action;
      logic [7:0] cell_index;
      logic       cell_is_solid;
      logic [8:0] column;
   } grcr_req_type;

   typedef struct packed {
      logic [8:0] out_column;
      logic [9:0] distance_steps;
      logic [7:0] wall_top;
      logic [7:0] wall_bottom;
      logic [7:0] shade;
   } grcr_rsp_type;

   function automatic logic [14:0] qsine(input logic [5:0] idx);
      logic [14:0] val;
      case (idx)
         6'd0:  val = 15'd0;     6'd1:  val = 15'd804;   6'd2:  val = 15'd1606;
         6'd3:  val = 15'd2404;  6'd4:  val = 15'd3196;  6'd5:  val = 15'd3981;
         6'd6:  val = 15'd4756;  6'd7:  val = 15'd5520;  6'd8:  val = 15'd6270;
         6'd9:  val = 15'd7005;  6'd10: val = 15'd7723;  6'd11: val = 15'd8423;
         6'd12: val = 15'd9102;  6'd13: val = 15'd9760;  6'd14: val = 15'd10394;
         6'd15: val = 15'd11003; 6'd16: val = 15'd11585; 6'd17: val = 15'd12140;
         6'd18: val = 15'd12665; 6'd19: val = 15'd13160; 6'd20: val = 15'd13623;
         6'd21: val = 15'd14053; 6'd22: val = 15'd14449; 6'd23: val = 15'd14811;
         6'd24: val = 15'd15137; 6'd25: val = 15'd15426; 6'd26: val = 15'd15679;
         6'd27: val = 15'd15893; 6'd28: val = 15'd16069; 6'd29: val = 15'd16207;
         6'd30: val = 15'd16305; 6'd31: val = 15'd16364;
         default: val = 15'd16384;
      endcase
      return val;
   endfunction

   // Quarter-wave lookup with linear interpolation; u is 0..16384.
   function automatic logic [14:0] quarter_lookup(input logic [14:0] u);
      logic [5:0]  idx;
      logic [8:0]  frac;
      logic [14:0] lo;
      logic [14:0] hi;
      logic [23:0] prod;
      idx  = u[14:9];
      frac = u[8:0];
      lo   = qsine(idx);
      hi   = qsine(idx + 6'd1);
      prod = 24'(hi - lo) * 24'(frac);
      if (idx >= 6'd32) begin
         return 15'd16384;
      end
      return lo + 15'(prod >> 9);
   endfunction

   // Signed Q1.14 sine of a 16-bit binary angle.
   function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
      logic [14:0] s;
      if (a[14]) begin
         s = quarter_lookup(15'd16384 - {1'b0, a[13:0]});
      end else begin
         s = quarter_lookup({1'b0, a[13:0]});
      end
      return a[15] ? -$signed({1'b0, s}) : $signed({1'b0, s});
   endfunction

endpackage

/* rtl/grcr_stream_if.sv */
// Valid/ready stream interface carrying one payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface grcr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/grcr_map_mem.sv */
// Map bitmap memory: one bit per cell, one write and one registered read port.
// Uses grcr_pkg.
`timescale 1ns / 1ps
module grcr_map_mem
   import grcr_pkg::*;
#(
   parameter int Cells = MapWidthDef * MapHeightDef
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Cells)-1:0] wr_addr,
   input  logic                     wr_data,
   input  logic [$clog2(Cells)-1:0] rd_addr,
   output logic                     rd_data
);
   logic mem [Cells];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/grcr_divider.sv */
// Restoring divider for the wall height: quotient = dividend / divisor.
// Uses grcr_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps
module grcr_divider
   import grcr_pkg::*;
#(
   parameter int NumW = 17,
   parameter int DenW = 13
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NumW-1:0] dividend,
   input  logic [DenW-1:0] divisor,
   output logic            done,
   output logic [NumW-1:0] quotient
);
   localparam int CntW = $clog2(NumW + 1);
   logic [NumW-1:0] quot_ff, quot_in;
   logic [DenW:0]   rem_ff, rem_in;
   logic [DenW-1:0] den_ff, den_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DenW:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DenW-1:0], quot_ff[NumW-1]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

/* rtl/grid_raycast_column_renderer_unit.sv */
// Grid raycast column renderer: map bitmap memory, ray marcher, wall slice divider.
// Uses grcr_pkg, grcr_stream_if, grcr_map_mem and grcr_divider.
// Map write: no result. Cast: setup (angle, sine, delta), then per step the states
// step, check (bounds test, map read issued) and finish (hit test), then the divider;
// a miss reports MaxSteps. One transaction at a time, input stalls while a result
// waits. Sync active-high reset restores control and CSR regs; map undefined.
`timescale 1ns / 1ps
module grid_raycast_column_renderer_unit
   import grcr_pkg::*;
#(
   parameter int MapWidth     = MapWidthDef,
   parameter int MapHeight    = MapHeightDef,
   parameter int ScreenWidth  = ScreenWidthDef,
   parameter int ScreenHeight = ScreenHeightDef,
   parameter int MaxSteps     = MaxStepsDef
) (
   input  logic                 clock,
   input  logic                 reset,
   grcr_stream_if.sink          req,
   grcr_stream_if.source        rsp,
   input  logic                 csr_we,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);
   localparam int Cells  = MapWidth * MapHeight;
   localparam int AddrW  = $clog2(Cells);
   localparam int MxW    = $clog2(MapWidth);
   localparam int MyW    = $clog2(MapHeight);
   localparam int StepW  = $clog2(MaxSteps + 1);
   localparam int NumV   = ScreenHeight * 50;
   localparam int NumW   = $clog2(NumV + 1);
   localparam int HalfH  = ScreenHeight / 2;
   // reciprocal of the screen width, exact for the product range of the offset
   localparam int DivK   = 34;
   localparam longint FovRecip = ((longint'(1) <<< DivK) + ScreenWidth - 1) / ScreenWidth;
   // reciprocal of 25 for the shade term floor(8*n/25)
   localparam int ShadeK = 20;
   localparam int ShadeRecip = ((1 << ShadeK) + 24) / 25;

   logic [15:0] player_x_ff, player_y_ff, player_angle_ff;
   logic [13:0] half_fov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff     <= 16'd32768;
         player_y_ff     <= 16'd32768;
         player_angle_ff <= 16'd0;
         half_fov_ff     <= 14'd5461;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PLAYER_X:     player_x_ff     <= csr_wdata;
            CSR_PLAYER_Y:     player_y_ff     <= csr_wdata;
            CSR_PLAYER_ANGLE: player_angle_ff <= csr_wdata;
            CSR_HALF_FOV:     half_fov_ff     <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   state_type         state_ff, state_in;
   logic [8:0]        col_ff, col_in;
   logic signed [26:0] prod_ff, prod_in;
   logic [15:0]       angle_ff, angle_in;
   logic signed [15:0] sin_ff, sin_in, cos_ff, cos_in;
   logic signed [39:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [45:0] x_ff, x_in, y_ff, y_in;
   logic [StepW-1:0]  n_ff, n_in;
   logic [StepW-1:0]  res_n_ff, res_n_in;
   logic [7:0]        top_ff, top_in, bot_ff, bot_in, shade_ff, shade_in;
   logic              div_start;
   logic [NumW-1:0]   div_q;
   logic              div_done;
   logic              map_rd;
   logic [AddrW-1:0]  rd_addr;
   logic              wr_en;
   logic [25:0]       prod_mag;
   logic [57:0]       quo_full;
   logic [23:0]       quo_mag;
   logic signed [26:0] offset;
   logic [45:0]       mx_full, my_full;
   logic              outside;
   logic [StepW+18:0] shade_prod;
   logic [StepW+4:0]  shq;
   logic [NumW-2:0]   half_h;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load_rsp;

   assign wr_en = req.valid && req.ready && req.data.action == ACTION_WRITE
                  && 32'(req.data.cell_index) < Cells;

   grcr_map_mem #(.Cells(Cells)) u_map (
      .clock(clock), .wr_en(wr_en), .wr_addr(AddrW'(req.data.cell_index)),
      .wr_data(req.data.cell_is_solid), .rd_addr(rd_addr), .rd_data(map_rd)
   );

   grcr_divider #(.NumW(NumW), .DenW(StepW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(NumW'(NumV)), .divisor(res_n_ff),
      .done(div_done), .quotient(div_q)
   );

   // Coordinates in Q38 cells; the integer part selects the cell.
   assign mx_full = 46'(x_ff >>> 38);
   assign my_full = 46'(y_ff >>> 38);
   assign outside = x_ff < 0 || y_ff < 0 || mx_full >= 46'(MapWidth)
                    || my_full >= 46'(MapHeight);
   assign rd_addr = AddrW'(my_full[MyW-1:0] * MapWidth + 32'(mx_full[MxW-1:0]));
   // truncate toward zero: divide the magnitude, then restore the sign
   assign prod_mag = prod_ff[26] ? 26'(-prod_ff) : 26'(prod_ff);
   assign quo_full = 58'(prod_mag) * 58'(FovRecip);
   assign quo_mag  = quo_full[DivK +: 24];
   assign offset   = prod_ff[26] ? -$signed({3'b0, quo_mag}) : $signed({3'b0, quo_mag});
   assign shade_prod = (StepW+19)'({res_n_ff, 3'b000}) * (StepW+19)'(ShadeRecip);
   assign shq     = (StepW+5)'(shade_prod >> ShadeK);
   assign half_h  = div_q[NumW-1:1];

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      prod_in   = prod_ff;
      angle_in  = angle_ff;
      sin_in    = sin_ff;
      cos_in    = cos_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      n_in      = n_ff;
      res_n_in  = res_n_ff;
      top_in    = top_ff;
      bot_in    = bot_ff;
      shade_in  = shade_ff;
      div_start = 1'b0;
      req.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // hold the input while a result waits
            req.ready = !rsp_valid_ff;
            if (req.valid && !rsp_valid_ff && req.data.action == ACTION_CAST) begin
               col_in   = req.data.column;
               prod_in  = (27'({req.data.column, 1'b0}) - 27'(ScreenWidth))
                          * 27'(half_fov_ff);
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            angle_in = player_angle_ff + 16'(offset);
            state_in = ST_SINE;
         end
         ST_SINE: begin
            sin_in   = sine_q14(angle_ff);
            cos_in   = sine_q14(angle_ff + 16'd16384);
            state_in = ST_DELTA;
         end
         ST_DELTA: begin
            dx_in    = 40'(sin_ff) * 40'($signed({1'b0, STEP_Q24}));
            dy_in    = 40'(cos_ff) * 40'($signed({1'b0, STEP_Q24}));
            x_in     = $signed({4'b0, player_x_ff, 26'd0});
            y_in     = $signed({4'b0, player_y_ff, 26'd0});
            n_in     = '0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            // advance one step; the memory read issues next cycle
            x_in     = x_ff + 46'(dx_ff);
            y_in     = y_ff + 46'(dy_ff);
            n_in     = n_ff + 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (outside) begin
               res_n_in = StepW'(MaxSteps);
               state_in = ST_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (map_rd) begin
               res_n_in = n_ff;
               state_in = ST_DIV;
            end else if (n_ff == StepW'(MaxSteps)) begin
               res_n_in = StepW'(MaxSteps);
               state_in = ST_DIV;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (div_done) begin
               top_in   = (32'(half_h) > HalfH) ? 8'd0 : 8'(HalfH - 32'(half_h));
               bot_in   = (32'(half_h) + HalfH > ScreenHeight - 1)
                          ? 8'(ScreenHeight - 1) : 8'(HalfH + 32'(half_h));
               shade_in = (shq > (StepW+5)'(SHADE_TOP - SHADE_FLOOR))
                          ? SHADE_FLOOR : 8'(SHADE_TOP - 8'(shq));
               state_in = ST_IDLE;
               n_in     = '1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: holds one result until taken.
   assign load_rsp = state_ff == ST_OUT && div_done;
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   assign rsp.valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff   <= col_in;
      prod_ff  <= prod_in;
      angle_ff <= angle_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      n_ff     <= n_in;
      res_n_ff <= res_n_in;
      top_ff   <= top_in;
      bot_ff   <= bot_in;
      shade_ff <= shade_in;
   end

   logic [8:0] out_col_ff;
   logic [StepW-1:0] out_n_ff;
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         out_col_ff <= col_ff;
         out_n_ff   <= res_n_ff;
      end
   end

   assign rsp.data.out_column     = out_col_ff;
   assign rsp.data.distance_steps = 10'(out_n_ff);
   assign rsp.data.wall_top       = top_ff;
   assign rsp.data.wall_bottom    = bot_ff;
   assign rsp.data.shade          = shade_ff;
endmodule

/* test/grid_raycast_column_renderer_unit_test.sv */
// Testbench for grid_raycast_column_renderer_unit: it loads the map, casts columns and
// checks every column result against a predictor inside this module.
// Depends on grcr_pkg, grcr_stream_if and the renderer RTL.
`timescale 1ns / 1ps
module grid_raycast_column_renderer_unit_test;
   import grcr_pkg::*;

   localparam int CycleLimit = 6000000;
   localparam int SettleCycles = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = CSR_PLAYER_X;
   logic [CsrDataW-1:0] csr_wdata = '0;

   grcr_stream_if #(.payload_type(grcr_req_type)) req_ch ();
   grcr_stream_if #(.payload_type(grcr_rsp_type)) rsp_ch ();

   grid_raycast_column_renderer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // viewer state and map mirror
   logic [15:0] view_x = 16'd32768;
   logic [15:0] view_y = 16'd32768;
   logic [15:0] view_angle = 16'd0;
   logic [13:0] view_half_fov = 14'd5461;
   bit solid_cells [MapWidthDef*MapHeightDef];

   grcr_req_type pending_items [$];
   grcr_rsp_type expected_slices [$];
   int items_queued = 0;
   int items_taken = 0;
   int errors = 0;
   int cycles = 0;
   bit idle_enable = 1'b1;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int req_gap = 0;
   int rsp_stall = 0;

   function automatic int table_sine(input int k);
      int q [33] = '{0, 804, 1606, 2404, 3196, 3981, 4756, 5520,
                     6270, 7005, 7723, 8423, 9102, 9760, 10394, 11003,
                     11585, 12140, 12665, 13160, 13623, 14053, 14449, 14811,
                     15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364,
                     16384};
      return q[k];
   endfunction

   function automatic longint ray_sine(input logic [15:0] a);
      int u;
      int k;
      int s;
      u = a[14] ? 16384 - int'(a[13:0]) : int'(a[13:0]);
      k = u >> 9;
      if (k >= 32) begin
         s = 16384;
      end else begin
         s = table_sine(k) + (((table_sine(k+1) - table_sine(k)) * (u & 511)) >> 9);
      end
      return a[15] ? -longint'(s) : longint'(s);
   endfunction

   function automatic int march_steps(input logic [15:0] a);
      longint dx;
      longint dy;
      longint px;
      longint py;
      longint mx;
      longint my;
      dx = ray_sine(a) * longint'(STEP_Q24);
      dy = ray_sine(a + 16'd16384) * longint'(STEP_Q24);
      px = longint'(view_x) <<< 26;
      py = longint'(view_y) <<< 26;
      for (int n = 1; n <= MaxStepsDef; n++) begin
         px += dx;
         py += dy;
         if (px < 0 || py < 0) return MaxStepsDef;
         mx = px >>> 38;
         my = py >>> 38;
         if (mx >= MapWidthDef || my >= MapHeightDef) return MaxStepsDef;
         if (solid_cells[my*MapWidthDef + mx]) return n;
      end
      return MaxStepsDef;
   endfunction

   function automatic grcr_rsp_type cast_column(input logic [8:0] col);
      grcr_rsp_type r;
      longint offset;
      logic [15:0] a;
      int n;
      int h;
      int top;
      int bottom;
      int shade;
      offset = ((2 * longint'(col)) - ScreenWidthDef) * longint'(view_half_fov)
               / ScreenWidthDef;
      a = 16'(longint'(view_angle) + offset);
      n = march_steps(a);
      h = (ScreenHeightDef * 50) / n;
      top = ScreenHeightDef / 2 - h / 2;
      bottom = ScreenHeightDef / 2 + h / 2;
      if (top < 0) top = 0;
      if (bottom > ScreenHeightDef - 1) bottom = ScreenHeightDef - 1;
      shade = 255 - (16 * n) / 50;
      if (shade < 25) shade = 25;
      r.out_column = col;
      r.distance_steps = 10'(n);
      r.wall_top = 8'(top);
      r.wall_bottom = 8'(bottom);
      r.shade = 8'(shade);
      return r;
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // accept transactions, predict, check
   always @(posedge clock) begin
      grcr_rsp_type exp_s;
      grcr_rsp_type got;
      if (!reset && req_ch.valid && req_ch.ready) begin
         req_taken = 1'b1;
         items_taken++;
         if (req_ch.data.action == ACTION_WRITE) begin
            if (int'(req_ch.data.cell_index) < MapWidthDef*MapHeightDef) begin
               solid_cells[req_ch.data.cell_index] = req_ch.data.cell_is_solid;
            end
         end else begin
            expected_slices.push_back(cast_column(req_ch.data.column));
         end
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_taken = 1'b1;
         got = rsp_ch.data;
         if (expected_slices.size() == 0) begin
            errors++;
            $display("%0t: unexpected result column %0d", $time, got.out_column);
         end else begin
            exp_s = expected_slices.pop_front();
            if (got.out_column !== exp_s.out_column) begin
               errors++;
               $display("%0t: out_column expected %0d got %0d", $time,
                        exp_s.out_column, got.out_column);
            end
            if (got.distance_steps !== exp_s.distance_steps) begin
               errors++;
               $display("%0t: distance_steps expected %0d got %0d", $time,
                        exp_s.distance_steps, got.distance_steps);
            end
            if (got.wall_top !== exp_s.wall_top) begin
               errors++;
               $display("%0t: wall_top expected %0d got %0d", $time,
                        exp_s.wall_top, got.wall_top);
            end
            if (got.wall_bottom !== exp_s.wall_bottom) begin
               errors++;
               $display("%0t: wall_bottom expected %0d got %0d", $time,
                        exp_s.wall_bottom, got.wall_bottom);
            end
            if (got.shade !== exp_s.shade) begin
               errors++;
               $display("%0t: shade expected %0d got %0d", $time,
                        exp_s.shade, got.shade);
            end
         end
      end
   end

   // drive requests and result backpressure
   always @(negedge clock) begin
      logic next_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
         rsp_ch.ready <= 1'b0;
      end else begin
         next_valid = req_ch.valid;
         if (req_taken) begin
            req_taken = 1'b0;
            next_valid = 1'b0;
            req_gap = idle_enable ? $urandom_range(0, 11) : 0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_items.size() > 0) begin
               req_ch.data <= pending_items.pop_front();
               next_valid = 1'b1;
            end
         end
         req_ch.valid <= next_valid;

         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_stall = idle_enable ? $urandom_range(0, 11) : 0;
         end
         if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   task automatic queue_write(input int idx, input bit solid);
      grcr_req_type it;
      it = '0;
      it.action = ACTION_WRITE;
      it.cell_index = 8'(idx);
      it.cell_is_solid = solid;
      it.column = 9'($urandom);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_cast(input int col);
      grcr_req_type it;
      it = '0;
      it.action = ACTION_CAST;
      it.cell_index = 8'($urandom);
      it.cell_is_solid = 1'($urandom);
      it.column = 9'(col);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic wait_idle();
      while (!(items_taken == items_queued && expected_slices.size() == 0)) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PLAYER_X:     view_x = value;
         CSR_PLAYER_Y:     view_y = value;
         CSR_PLAYER_ANGLE: view_angle = value;
         CSR_HALF_FOV:     view_half_fov = value[13:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_view(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] a, input logic [15:0] fov);
      write_csr(CSR_PLAYER_X, x);
      write_csr(CSR_PLAYER_Y, y);
      write_csr(CSR_PLAYER_ANGLE, a);
      write_csr(CSR_HALF_FOV, fov);
   endtask

   initial begin
      int r;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // define every cell before any cast: solid border, sparse interior
      for (int i = 0; i < MapWidthDef*MapHeightDef; i++) begin
         if (i / MapWidthDef == 0 || i / MapWidthDef == MapHeightDef - 1 ||
             i % MapWidthDef == 0 || i % MapWidthDef == MapWidthDef - 1) begin
            queue_write(i, 1'b1);
         end else begin
            queue_write(i, ($urandom_range(0, 9) == 0));
         end
      end
      queue_cast(0);
      queue_cast(319);
      queue_cast(160);
      queue_cast(511);
      queue_cast(320);
      // open a border cell to the right of center and cast straight at it
      queue_write(8*MapWidthDef + 15, 1'b0);
      queue_write(8*MapWidthDef + 9, 1'b0);
      wait_idle();
      set_view(16'd32768, 16'd32768, 16'd16384, 16'd0);
      queue_cast(0);
      queue_cast(255);
      wait_idle();
      // corners and range extremes
      set_view(16'd0, 16'd0, 16'h8000, 16'd16383);
      queue_cast(0);
      queue_cast(319);
      queue_cast(160);
      wait_idle();
      set_view(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'd16383);
      queue_cast(0);
      queue_cast(319);
      queue_cast(511);
      queue_write(8*MapWidthDef + 15, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 5; phase++) begin
         idle_enable = (phase != 2);
         set_view(16'($urandom_range(4096, 61439)), 16'($urandom_range(4096, 61439)),
                  16'($urandom), 16'($urandom_range(0, 16383)));
         for (int k = 0; k < 64; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
               queue_write($urandom_range(0, 255), ($urandom_range(0, 9) < 6));
            end else if (r < 38) begin
               queue_cast($urandom_range(320, 511));
            end else begin
               queue_cast($urandom_range(0, 319));
            end
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/grcr_pkg.sv
rtl/grcr_stream_if.sv
rtl/grcr_map_mem.sv
rtl/grcr_divider.sv
rtl/grid_raycast_column_renderer_unit.sv
test/grid_raycast_column_renderer_unit_test.sv
